// ===== rtl/klc_pkg.sv =====
// Shared types and constants of the keyed result cache.
`timescale 1ns / 1ps

package klc_pkg;

   // Operation codes carried in the request tuser field.
   localparam logic [1:0] KIND_LOOKUP = 2'd0;
   localparam logic [1:0] KIND_INSERT = 2'd1;
   localparam logic [1:0] KIND_PURGE  = 2'd2;

   // A key matches a purge tag when key XOR tag falls below this bound.
   localparam logic [31:0] PURGE_LIMIT = 32'h0001_0000;

   // Payload of one cache entry, apart from its use stamp.
   typedef struct packed {
      logic [31:0] key;
      logic [15:0] width;
      logic [15:0] height;
      logic [15:0] handle;
   } entry_type;

   // Write request from the sequencer to the entry store.
   typedef struct packed {
      logic        entry_en;
      logic        stamp_en;
      entry_type   entry;
      logic [31:0] stamp;
   } store_wr_type;

endpackage

// ===== rtl/klc_entry_store.sv =====
// Entry and use-stamp memories with one write port and one registered read port.
`timescale 1ns / 1ps

module klc_entry_store #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                  clock,
   input  klc_pkg::store_wr_type wr,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output klc_pkg::entry_type    rd_entry,
   output logic [31:0]           rd_stamp
);

   klc_pkg::entry_type entry_mem [DEPTH];
   logic [31:0]        stamp_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr.entry_en) begin
         entry_mem[wr_addr] <= wr.entry;
      end
      if (wr.stamp_en) begin
         stamp_mem[wr_addr] <= wr.stamp;
      end
   end

   // The read data holds while rd_en is low, so a stalled scan keeps its entry.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry <= entry_mem[rd_addr];
         rd_stamp <= stamp_mem[rd_addr];
      end
   end

endmodule

// ===== rtl/keyed_lru_result_cache_unit.sv =====
// Top level of the keyed result cache with least-recently-used replacement.
`timescale 1ns / 1ps

// A fully associative cache of CAPACITY entries, each holding a 32-bit key,
// a width, a height and a handle. Requests arrive as items on the req_
// stream: tuser carries the operation (lookup, insert or purge by tag) and
// tdata the key, the entry data and the purge tag. Results leave as items
// on the rsp_ stream, one per request, or for a purge one per removed entry
// (and at least one), with tlast set on the final item of each request.
// A single sequencer walks the entry memory through its one read port, one
// entry per cycle unless a purge stalls, and one shared comparator judges
// each entry. A lookup ends early on a hit. req_tready is low from taking
// a request until its last result enters the output register, including
// any stall of the receiver, so no new item is taken before the last is
// done. The result sits in an output register; a purge keeps one further
// removed entry pending, and its scan halts when another removal finds
// both full and rsp_tready low, so no item is lost.
// A synchronous reset clears the valid bits, the occupancy count and the use
// counter at once; the entry memories are not cleared and need no pass, as
// an entry is used only once its valid bit is set.

module keyed_lru_result_cache_unit #(
   parameter int CAPACITY = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // [31:0] key, [47:32] entry_width, [63:48] entry_height,
   // [79:64] entry_handle, [111:80] purge_tag
   input  logic [111:0]  req_tdata,
   // [1:0] kind
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [15:0] found_width, [31:16] found_height, [47:32] found_handle,
   // [63:48] released_handle
   output logic [63:0]   rsp_tdata,
   // [0] hit, [1] evicted
   output logic [1:0]    rsp_tuser,
   output logic          rsp_tlast
);

   localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_INSERT,
      ST_REPLY,
      ST_PURGE_END
   } state_type;

   state_type             state_ff, state_in;
   logic [1:0]            kind_ff, kind_in;
   logic [31:0]           key_ff, key_in;
   logic [15:0]           ew_ff, ew_in;
   logic [15:0]           eh_ff, eh_in;
   logic [15:0]           ehd_ff, ehd_in;
   logic [31:0]           tag_ff, tag_in;
   logic [CNT_W-1:0]      addr_ff, addr_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic [SLOT_W-1:0]     chk_idx_ff, chk_idx_in;
   logic [CAPACITY-1:0]   valid_ff, valid_in;
   logic [CNT_W-1:0]      occ_ff, occ_in;
   logic [31:0]           cnt_ff, cnt_in;
   logic                  best_vld_ff, best_vld_in;
   logic [SLOT_W-1:0]     best_idx_ff, best_idx_in;
   logic [31:0]           best_stamp_ff, best_stamp_in;
   logic [15:0]           best_handle_ff, best_handle_in;
   logic                  free_vld_ff, free_vld_in;
   logic [SLOT_W-1:0]     free_idx_ff, free_idx_in;
   logic                  found_ff, found_in;
   logic [SLOT_W-1:0]     found_idx_ff, found_idx_in;
   logic [15:0]           found_w_ff, found_w_in;
   logic [15:0]           found_h_ff, found_h_in;
   logic [15:0]           found_hd_ff, found_hd_in;
   logic                  pend_vld_ff, pend_vld_in;
   logic [15:0]           pend_handle_ff, pend_handle_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [63:0]           rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]            rsp_tuser_ff, rsp_tuser_in;
   logic                  rsp_tlast_ff, rsp_tlast_in;

   klc_pkg::store_wr_type store_wr;
   logic [SLOT_W-1:0]     wr_addr;
   logic                  rd_en;
   klc_pkg::entry_type    rd_entry;
   logic [31:0]           rd_stamp;

   // Shared comparator: one operand pair per cycle, chosen by the operation.
   logic [31:0] cmp_a, cmp_b;
   logic        cmp_eq, cmp_lt;
   logic        chk_live, look_match, purge_match, rsp_free, stall;
   logic        evict, slot_ok;
   logic [SLOT_W-1:0] ins_slot;

   klc_entry_store #(
      .DEPTH  (CAPACITY),
      .ADDR_W (SLOT_W)
   ) u_store (
      .clock    (clock),
      .wr       (store_wr),
      .wr_addr  (wr_addr),
      .rd_en    (rd_en),
      .rd_addr  (addr_ff[SLOT_W-1:0]),
      .rd_entry (rd_entry),
      .rd_stamp (rd_stamp)
   );

   always_comb begin
      case (kind_ff)
         klc_pkg::KIND_LOOKUP: begin
            cmp_a = rd_entry.key;
            cmp_b = key_ff;
         end
         klc_pkg::KIND_INSERT: begin
            cmp_a = rd_stamp;
            cmp_b = best_stamp_ff;
         end
         klc_pkg::KIND_PURGE: begin
            cmp_a = rd_entry.key ^ tag_ff;
            cmp_b = klc_pkg::PURGE_LIMIT;
         end
         default: begin
            cmp_a = 32'd0;
            cmp_b = 32'd0;
         end
      endcase
   end

   assign cmp_eq      = (cmp_a == cmp_b);
   assign cmp_lt      = (cmp_a < cmp_b);
   assign chk_live    = chk_vld_ff && valid_ff[chk_idx_ff];
   assign look_match  = chk_live && cmp_eq;
   assign purge_match = chk_live && cmp_lt;
   assign rsp_free    = !rsp_tvalid_ff || rsp_tready;

   // A purge halts when a new removal finds both the pending slot and the
   // output register occupied, with rsp_tready low.
   assign stall = (state_ff == ST_SCAN) && (kind_ff == klc_pkg::KIND_PURGE) &&
                  purge_match && pend_vld_ff && !rsp_free;

   // On a full table the least recently used entry is evicted and its slot reused.
   assign evict    = (occ_ff >= CAP_CNT) && best_vld_ff;
   assign ins_slot = evict ? best_idx_ff : free_idx_ff;
   assign slot_ok  = evict || free_vld_ff;

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      key_in         = key_ff;
      ew_in          = ew_ff;
      eh_in          = eh_ff;
      ehd_in         = ehd_ff;
      tag_in         = tag_ff;
      addr_in        = addr_ff;
      chk_vld_in     = chk_vld_ff;
      chk_idx_in     = chk_idx_ff;
      valid_in       = valid_ff;
      occ_in         = occ_ff;
      cnt_in         = cnt_ff;
      best_vld_in    = best_vld_ff;
      best_idx_in    = best_idx_ff;
      best_stamp_in  = best_stamp_ff;
      best_handle_in = best_handle_ff;
      free_vld_in    = free_vld_ff;
      free_idx_in    = free_idx_ff;
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      found_w_in     = found_w_ff;
      found_h_in     = found_h_ff;
      found_hd_in    = found_hd_ff;
      pend_vld_in    = pend_vld_ff;
      pend_handle_in = pend_handle_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in   = rsp_tdata_ff;
      rsp_tuser_in   = rsp_tuser_ff;
      rsp_tlast_in   = rsp_tlast_ff;
      store_wr       = '0;
      wr_addr        = found_idx_ff;
      rd_en          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in     = req_tuser;
               key_in      = req_tdata[31:0];
               ew_in       = req_tdata[47:32];
               eh_in       = req_tdata[63:48];
               ehd_in      = req_tdata[79:64];
               tag_in      = req_tdata[111:80];
               addr_in     = '0;
               chk_vld_in  = 1'b0;
               best_vld_in = 1'b0;
               free_vld_in = 1'b0;
               found_in    = 1'b0;
               pend_vld_in = 1'b0;
               if (req_tuser == klc_pkg::KIND_LOOKUP || req_tuser == klc_pkg::KIND_INSERT ||
                   req_tuser == klc_pkg::KIND_PURGE) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_REPLY;
               end
            end
         end

         ST_SCAN: begin
            if (!stall) begin
               // Issue the next read while the previous entry is judged.
               if (addr_ff != CAP_CNT) begin
                  rd_en      = 1'b1;
                  addr_in    = addr_ff + 1'b1;
                  chk_vld_in = 1'b1;
                  chk_idx_in = addr_ff[SLOT_W-1:0];
               end else begin
                  chk_vld_in = 1'b0;
                  case (kind_ff)
                     klc_pkg::KIND_INSERT: state_in = ST_INSERT;
                     klc_pkg::KIND_PURGE:  state_in = ST_PURGE_END;
                     default:              state_in = ST_REPLY;
                  endcase
               end

               case (kind_ff)
                  klc_pkg::KIND_LOOKUP: begin
                     if (look_match) begin
                        found_in     = 1'b1;
                        found_idx_in = chk_idx_ff;
                        found_w_in   = rd_entry.width;
                        found_h_in   = rd_entry.height;
                        found_hd_in  = rd_entry.handle;
                        chk_vld_in   = 1'b0;
                        state_in     = ST_REPLY;
                     end
                  end
                  klc_pkg::KIND_INSERT: begin
                     if (chk_live && (!best_vld_ff || cmp_lt)) begin
                        best_vld_in    = 1'b1;
                        best_idx_in    = chk_idx_ff;
                        best_stamp_in  = rd_stamp;
                        best_handle_in = rd_entry.handle;
                     end
                     if (chk_vld_ff && !valid_ff[chk_idx_ff] && !free_vld_ff) begin
                        free_vld_in = 1'b1;
                        free_idx_in = chk_idx_ff;
                     end
                  end
                  klc_pkg::KIND_PURGE: begin
                     if (purge_match) begin
                        valid_in[chk_idx_ff] = 1'b0;
                        if (occ_ff != '0) begin
                           occ_in = occ_ff - 1'b1;
                        end
                        // The earlier removal is known not to be the last.
                        if (pend_vld_ff) begin
                           rsp_tvalid_in = 1'b1;
                           rsp_tdata_in  = {pend_handle_ff, 48'd0};
                           rsp_tuser_in  = 2'b10;
                           rsp_tlast_in  = 1'b0;
                        end
                        pend_vld_in    = 1'b1;
                        pend_handle_in = rd_entry.handle;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_INSERT: begin
            if (rsp_free) begin
               if (evict) begin
                  valid_in[best_idx_ff] = 1'b0;
               end
               if (slot_ok) begin
                  wr_addr               = ins_slot;
                  store_wr.entry_en     = 1'b1;
                  store_wr.stamp_en     = 1'b1;
                  store_wr.entry.key    = key_ff;
                  store_wr.entry.width  = ew_ff;
                  store_wr.entry.height = eh_ff;
                  store_wr.entry.handle = ehd_ff;
                  store_wr.stamp        = cnt_ff + 32'd1;
                  cnt_in                = cnt_ff + 32'd1;
                  valid_in[ins_slot]    = 1'b1;
               end
               if (slot_ok && !evict) begin
                  occ_in = occ_ff + 1'b1;
               end else if (!slot_ok && evict) begin
                  occ_in = occ_ff - 1'b1;
               end
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {(evict ? best_handle_ff : 16'd0), 48'd0};
               rsp_tuser_in  = {evict, 1'b0};
               rsp_tlast_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         ST_REPLY: begin
            // Lookup result, hit or miss, and the reply to an unused code.
            if (rsp_free) begin
               if (found_ff) begin
                  wr_addr           = found_idx_ff;
                  store_wr.stamp_en = 1'b1;
                  store_wr.stamp    = cnt_ff + 32'd1;
                  cnt_in            = cnt_ff + 32'd1;
                  rsp_tdata_in      = {16'd0, found_hd_ff, found_h_ff, found_w_ff};
                  rsp_tuser_in      = 2'b01;
               end else begin
                  rsp_tdata_in = '0;
                  rsp_tuser_in = 2'b00;
               end
               rsp_tvalid_in = 1'b1;
               rsp_tlast_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         ST_PURGE_END: begin
            if (rsp_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {(pend_vld_ff ? pend_handle_ff : 16'd0), 48'd0};
               rsp_tuser_in  = {pend_vld_ff, 1'b0};
               rsp_tlast_in  = 1'b1;
               pend_vld_in   = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         chk_vld_ff    <= 1'b0;
         valid_ff      <= '0;
         occ_ff        <= '0;
         cnt_ff        <= '0;
         best_vld_ff   <= 1'b0;
         free_vld_ff   <= 1'b0;
         found_ff      <= 1'b0;
         pend_vld_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         addr_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         chk_vld_ff    <= chk_vld_in;
         valid_ff      <= valid_in;
         occ_ff        <= occ_in;
         cnt_ff        <= cnt_in;
         best_vld_ff   <= best_vld_in;
         free_vld_ff   <= free_vld_in;
         found_ff      <= found_in;
         pend_vld_ff   <= pend_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         addr_ff       <= addr_in;
      end
      kind_ff        <= kind_in;
      key_ff         <= key_in;
      ew_ff          <= ew_in;
      eh_ff          <= eh_in;
      ehd_ff         <= ehd_in;
      tag_ff         <= tag_in;
      chk_idx_ff     <= chk_idx_in;
      best_idx_ff    <= best_idx_in;
      best_stamp_ff  <= best_stamp_in;
      best_handle_ff <= best_handle_in;
      free_idx_ff    <= free_idx_in;
      found_idx_ff   <= found_idx_in;
      found_w_ff     <= found_w_in;
      found_h_ff     <= found_h_in;
      found_hd_ff    <= found_hd_in;
      pend_handle_ff <= pend_handle_in;
      rsp_tdata_ff   <= rsp_tdata_in;
      rsp_tuser_ff   <= rsp_tuser_in;
      rsp_tlast_ff   <= rsp_tlast_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // The occupancy count always matches the number of valid entries.
   a_occ_matches_valid: assert property (@(posedge clock) disable iff (reset)
      int'(occ_ff) == $countones(valid_ff))
      else $error("occupancy count differs from the number of valid entries");

   // No purge removal may be left pending once the block is idle again.
   a_no_pending_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_vld_ff)
      else $error("purge removal left pending at idle");

   // A lookup hit refreshes the stamp of an entry that is still valid.
   a_hit_entry_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPLY && found_ff) |-> valid_ff[found_idx_ff])
      else $error("lookup hit points at an invalid entry");

   // A stalled purge scan neither advances nor loses the entry under check.
   a_stall_holds_scan: assert property (@(posedge clock) disable iff (reset)
      stall |=> ($stable(addr_ff) && $stable(chk_idx_ff) && chk_vld_ff))
      else $error("purge scan moved while stalled");

endmodule
